>>> hw/rtl/accalu_pkg.sv
// ----------------------------------------------------------------------------
// accalu_pkg
// Shared types and codes for the accumulator ALU with decimal adjust:
// operation codes, flag bit positions and the packed input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

package accalu_pkg;

    // Operation codes carried in the func field.
    localparam logic [3:0] FUNC_ADD   = 4'd0;
    localparam logic [3:0] FUNC_ADC   = 4'd1;
    localparam logic [3:0] FUNC_SUB   = 4'd2;
    localparam logic [3:0] FUNC_SBC   = 4'd3;
    localparam logic [3:0] FUNC_CP    = 4'd4;
    localparam logic [3:0] FUNC_INC8  = 4'd5;
    localparam logic [3:0] FUNC_DEC8  = 4'd6;
    localparam logic [3:0] FUNC_CCF   = 4'd7;
    localparam logic [3:0] FUNC_SCF   = 4'd8;
    localparam logic [3:0] FUNC_DAA   = 4'd9;
    localparam logic [3:0] FUNC_CPL   = 4'd10;
    localparam logic [3:0] FUNC_INC16 = 4'd11;
    localparam logic [3:0] FUNC_DEC16 = 4'd12;
    localparam logic [3:0] FUNC_ADDHL = 4'd13;
    localparam logic [3:0] FUNC_ADDSP = 4'd14;

    // Flag bit positions within the flag nibble.
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Decimal adjust constants.
    localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
    localparam logic [7:0] BCD_BYTE_MAX  = 8'h99;
    localparam logic [7:0] BCD_ADJ_LO    = 8'h06;
    localparam logic [7:0] BCD_ADJ_HI    = 8'h60;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 40;

    // Input word; the last field sits in the lowest bits.
    typedef struct packed {
        logic [15:0] wide_b;
        logic [15:0] wide_a;
        logic [7:0]  operand;
        logic [3:0]  flags_in;
        logic [7:0]  acc_in;
        logic [3:0]  func;
    } in_item_t;

    // Result word; the last field sits in the lowest bits.
    typedef struct packed {
        logic [15:0] wide_result;
        logic [7:0]  byte_result;
        logic [3:0]  flags_out;
        logic [7:0]  acc_out;
    } out_item_t;

    // Accumulator and flags passed to and from the decimal adjust unit.
    typedef struct packed {
        logic [7:0] acc;
        logic [3:0] flags;
    } acc_flags_t;

endpackage : accalu_pkg

`default_nettype wire

>>> hw/rtl/accalu_daa.sv
// ----------------------------------------------------------------------------
// accalu_daa
// Decimal adjust of the accumulator after a BCD add or subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module accalu_daa (
    input  accalu_pkg::acc_flags_t src,
    output accalu_pkg::acc_flags_t dst
);

    logic       n_flag;
    logic       h_flag;
    logic       c_flag;
    logic [7:0] adj;
    logic       carry;
    logic [7:0] result;

    assign n_flag = src.flags[accalu_pkg::FLAG_N];
    assign h_flag = src.flags[accalu_pkg::FLAG_H];
    assign c_flag = src.flags[accalu_pkg::FLAG_C];

    // Choose the correction from the previous operation's direction and flags.
    always_comb
    begin
        adj   = 8'h00;
        carry = c_flag;
        if (!n_flag)
        begin
            if (h_flag || (src.acc[3:0] > accalu_pkg::BCD_DIGIT_MAX))
            begin
                adj = adj | accalu_pkg::BCD_ADJ_LO;
            end
            if (c_flag || (src.acc > accalu_pkg::BCD_BYTE_MAX))
            begin
                adj   = adj | accalu_pkg::BCD_ADJ_HI;
                carry = 1'b1;
            end
            result = src.acc + adj;
        end
        else
        begin
            if (h_flag)
            begin
                adj = adj | accalu_pkg::BCD_ADJ_LO;
            end
            if (c_flag)
            begin
                adj = adj | accalu_pkg::BCD_ADJ_HI;
            end
            result = src.acc - adj;
        end
    end

    // Half carry is always cleared; N is kept.
    assign dst.acc   = result;
    assign dst.flags = {(result == 8'h00), n_flag, 1'b0, carry};

endmodule : accalu_daa

`default_nettype wire

>>> hw/rtl/accalu_exec.sv
// ----------------------------------------------------------------------------
// accalu_exec
// Combinational execute logic: the 8-bit and 16-bit arithmetic and the flags.
// ----------------------------------------------------------------------------
`default_nettype none

module accalu_exec (
    input  accalu_pkg::in_item_t  item,
    output accalu_pkg::out_item_t result
);

    logic                   cin;
    logic                   use_carry;
    logic [8:0]             add_sum;
    logic [4:0]             add_half;
    logic [8:0]             sub_diff;
    logic [4:0]             sub_half;
    logic [3:0]             add_flags;
    logic [3:0]             sub_flags;
    logic [7:0]             inc_byte;
    logic [7:0]             dec_byte;
    logic [16:0]            hl_sum;
    logic [12:0]            hl_half;
    logic [15:0]            sp_sum;
    logic [4:0]             sp_half;
    logic [8:0]             sp_low;
    accalu_pkg::acc_flags_t daa_src;
    accalu_pkg::acc_flags_t daa_dst;

    assign cin       = item.flags_in[accalu_pkg::FLAG_C];
    assign use_carry = cin && ((item.func == accalu_pkg::FUNC_ADC) ||
                               (item.func == accalu_pkg::FUNC_SBC));

    // Byte adder and subtractor shared by ADD, ADC, SUB, SBC and CP.
    assign add_sum  = {1'b0, item.acc_in} + {1'b0, item.operand} + {8'h00, use_carry};
    assign add_half = {1'b0, item.acc_in[3:0]} + {1'b0, item.operand[3:0]}
                    + {4'h0, use_carry};
    assign sub_diff = {1'b0, item.acc_in} - {1'b0, item.operand} - {8'h00, use_carry};
    assign sub_half = {1'b0, item.acc_in[3:0]} - {1'b0, item.operand[3:0]}
                    - {4'h0, use_carry};

    assign add_flags = {(add_sum[7:0] == 8'h00), 1'b0, add_half[4], add_sum[8]};
    assign sub_flags = {(sub_diff[7:0] == 8'h00), 1'b1, sub_half[4], sub_diff[8]};

    // Increment and decrement of the byte operand.
    assign inc_byte = item.operand + 8'h01;
    assign dec_byte = item.operand - 8'h01;

    // Sixteen-bit add into HL, half carry out of bit 11.
    assign hl_sum  = {1'b0, item.wide_a} + {1'b0, item.wide_b};
    assign hl_half = {1'b0, item.wide_a[11:0]} + {1'b0, item.wide_b[11:0]};

    // Stack pointer plus signed offset; flags come from the low byte add.
    assign sp_sum  = item.wide_a + {{8{item.operand[7]}}, item.operand};
    assign sp_half = {1'b0, item.wide_a[3:0]} + {1'b0, item.operand[3:0]};
    assign sp_low  = {1'b0, item.wide_a[7:0]} + {1'b0, item.operand};

    assign daa_src.acc   = item.acc_in;
    assign daa_src.flags = item.flags_in;

    accalu_daa u_daa (
        .src (daa_src),
        .dst (daa_dst)
    );

    // Select the result and flags for the operation.
    always_comb
    begin
        result.acc_out     = item.acc_in;
        result.flags_out   = item.flags_in;
        result.byte_result = 8'h00;
        result.wide_result = 16'h0000;
        unique case (item.func)
            accalu_pkg::FUNC_ADD,
            accalu_pkg::FUNC_ADC:
            begin
                result.acc_out   = add_sum[7:0];
                result.flags_out = add_flags;
            end
            accalu_pkg::FUNC_SUB,
            accalu_pkg::FUNC_SBC:
            begin
                result.acc_out   = sub_diff[7:0];
                result.flags_out = sub_flags;
            end
            accalu_pkg::FUNC_CP:
            begin
                result.flags_out = sub_flags;
            end
            accalu_pkg::FUNC_INC8:
            begin
                result.byte_result = inc_byte;
                result.flags_out   = {(inc_byte == 8'h00), 1'b0,
                                      (item.operand[3:0] == 4'hF), cin};
            end
            accalu_pkg::FUNC_DEC8:
            begin
                result.byte_result = dec_byte;
                result.flags_out   = {(dec_byte == 8'h00), 1'b1,
                                      (item.operand[3:0] == 4'h0), cin};
            end
            accalu_pkg::FUNC_CCF:
            begin
                result.flags_out = {item.flags_in[accalu_pkg::FLAG_Z], 2'b00, ~cin};
            end
            accalu_pkg::FUNC_SCF:
            begin
                result.flags_out = {item.flags_in[accalu_pkg::FLAG_Z], 3'b001};
            end
            accalu_pkg::FUNC_DAA:
            begin
                result.acc_out   = daa_dst.acc;
                result.flags_out = daa_dst.flags;
            end
            accalu_pkg::FUNC_CPL:
            begin
                result.acc_out   = ~item.acc_in;
                result.flags_out = item.flags_in | 4'b0110;
            end
            accalu_pkg::FUNC_INC16:
            begin
                result.wide_result = item.wide_a + 16'h0001;
            end
            accalu_pkg::FUNC_DEC16:
            begin
                result.wide_result = item.wide_a - 16'h0001;
            end
            accalu_pkg::FUNC_ADDHL:
            begin
                result.wide_result = hl_sum[15:0];
                result.flags_out   = {item.flags_in[accalu_pkg::FLAG_Z], 1'b0,
                                      hl_half[12], hl_sum[16]};
            end
            accalu_pkg::FUNC_ADDSP:
            begin
                result.wide_result = sp_sum;
                result.flags_out   = {2'b00, sp_half[4], sp_low[8]};
            end
            default:
            begin
                // The spare operation code keeps the accumulator and flags and gives zero results.
                result.acc_out = item.acc_in;
            end
        endcase
    end

endmodule : accalu_exec

`default_nettype wire

>>> hw/rtl/accumulator_alu_with_bcd_adjust_core.sv
// ----------------------------------------------------------------------------
// accumulator_alu_with_bcd_adjust_core
// Eight-bit CPU arithmetic unit with decimal adjust and 16-bit helpers.
// ----------------------------------------------------------------------------
// Each word on the input stream carries one operation with the accumulator,
// flags and operands, and produces exactly one result word. A new word is
// accepted in every cycle while the output stream is not stalled, and its
// result is offered once the word has moved from the input register into
// the result register. The combinational execute logic works out the result
// while the word waits in the input register. The unit holds no state
// between words, so reset only empties the two registers, and a stalled
// output stream holds back the input once both registers are full.
`default_nettype none

module accumulator_alu_with_bcd_adjust_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output      logic                             s_axis_tready,
    // func, acc_in, flags_in, operand, wide_a, wide_b (lowest bit up)
    input  wire logic [accalu_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output      logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // acc_out, flags_out, byte_result, wide_result, then four zero bits
    output      logic [accalu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    accalu_pkg::in_item_t  in_item_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    accalu_pkg::out_item_t out_item_reg;
    accalu_pkg::out_item_t alu_result;
    logic                  out_ready;
    logic                  in_ready;

    // The result register frees when empty or taken; the input register
    // frees when empty or moving on into the result register.
    assign out_ready = !out_valid_reg || m_axis_tready;
    assign in_ready  = !in_valid_reg || out_ready;

    always_comb
    begin
        in_valid_next  = in_ready ? s_axis_tvalid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    // Stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && in_ready)
        begin
            in_item_reg <= accalu_pkg::in_item_t'(s_axis_tdata);
        end
        if (in_valid_reg && out_ready)
        begin
            out_item_reg <= alu_result;
        end
    end

    accalu_exec u_exec (
        .item   (in_item_reg),
        .result (alu_result)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, out_item_reg};

    // A full input register must hold back new words while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

    // An accepted word is held in the input register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("accepted word lost from the input register");

    // A word moving on lands in the result register with its computed value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_ready) |=>
            (m_axis_tvalid && (out_item_reg == $past(alu_result))))
        else $error("result register does not hold the executed word");

endmodule : accumulator_alu_with_bcd_adjust_core

`default_nettype wire
